// File: rtl/pfc_pkg.sv
package pfc_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int SLOT_W        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int ADDR_W        = 32;
    localparam int INDEX_W       = 4;
    localparam int PREFIX_W      = 6;
    localparam logic [PREFIX_W-1:0] PREFIX_MAX = PREFIX_W'(ADDR_W);

    typedef enum logic
    {
        CMD_WRITE  = 1'b0,
        CMD_LOOKUP = 1'b1
    } command_t;

    typedef struct packed
    {
        command_t            command;
        logic [INDEX_W-1:0]  entry_index;
        logic                entry_valid;
        logic [ADDR_W-1:0]   entry_net;
        logic [PREFIX_W-1:0] entry_prefix;
        logic [ADDR_W-1:0]   query_addr;
    } request_t;

    typedef struct packed
    {
        logic               matched;
        logic [INDEX_W-1:0] match_index;
        logic [ADDR_W-1:0]  result_addr;
    } result_t;

    // table write port
    typedef struct packed
    {
        logic              en;
        logic [SLOT_W-1:0] slot;
        logic              valid;
        logic [ADDR_W-1:0] net;
        logic [ADDR_W-1:0] mask;
    } table_wr_t;

    typedef struct packed
    {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic [ADDR_W-1:0] net;
    } match_t;

    // prefix length to network mask, lengths above 32 saturate
    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PREFIX_W-1:0] plen);
        logic [PREFIX_W-1:0] sat;
        sat = (plen > PREFIX_MAX) ? PREFIX_MAX : plen;
        if (sat == '0)
        begin
            return '0;
        end
        return {ADDR_W{1'b1}} << (PREFIX_MAX - sat);
    endfunction

endpackage

// File: rtl/pfc_table.sv
module pfc_table
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  pfc_pkg::table_wr_t        wr,
    output logic [pfc_pkg::ADDR_W-1:0] net  [pfc_pkg::TABLE_ENTRIES],
    output logic [pfc_pkg::ADDR_W-1:0] mask [pfc_pkg::TABLE_ENTRIES],
    output logic [pfc_pkg::TABLE_ENTRIES-1:0] valid
);
    import pfc_pkg::*;

    logic [ADDR_W-1:0]        net_reg  [TABLE_ENTRIES];
    logic [ADDR_W-1:0]        mask_reg [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.en)
        begin
            valid_reg[wr.slot] <= wr.valid;
        end
    end

    // base and mask are stored even when the slot is being removed
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            net_reg[wr.slot]  <= wr.net;
            mask_reg[wr.slot] <= wr.mask;
        end
    end

    assign net   = net_reg;
    assign mask  = mask_reg;
    assign valid = valid_reg;

endmodule

// File: rtl/pfc_match.sv
module pfc_match
(
    input  logic [pfc_pkg::ADDR_W-1:0]        query,
    input  logic [pfc_pkg::ADDR_W-1:0]        net  [pfc_pkg::TABLE_ENTRIES],
    input  logic [pfc_pkg::ADDR_W-1:0]        mask [pfc_pkg::TABLE_ENTRIES],
    input  logic [pfc_pkg::TABLE_ENTRIES-1:0] valid,
    output pfc_pkg::match_t                   match
);
    import pfc_pkg::*;

    logic [TABLE_ENTRIES-1:0] hit_vec;

    always_comb
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            hit_vec[i] = valid[i] && ((query & mask[i]) == net[i]);
        end
    end

    // priority select: walk from the top so the lowest slot wins
    always_comb
    begin
        match.hit  = 1'b0;
        match.slot = '0;
        match.net  = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (hit_vec[i])
            begin
                match.hit  = 1'b1;
                match.slot = SLOT_W'(i);
                match.net  = net[i];
            end
        end
    end

endmodule

// File: rtl/ipv4_first_match_prefix_classifier_core.sv
// channel   | handshake        | payload
// ----------+------------------+-------------------
// request   | start / busy     | request (request_t)
// result    | done (strobe)    | result  (result_t)
//
// One item per cycle; busy stays low. Each item gives one result via the
// input register, then parallel masked compares over all slots and a
// priority select into the result register.
// A write updates the table at the same edge its result is registered, so the
// next item already sees it. rst_n clears the slot valid bits at once.
// Results are not held: done is high for one cycle per item.
module ipv4_first_match_prefix_classifier_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  pfc_pkg::request_t request,
    output logic              done,
    output pfc_pkg::result_t  result
);
    import pfc_pkg::*;

    logic     in_vld_reg;
    request_t in_reg;
    logic     done_reg;
    result_t  result_reg;
    result_t  result_next;

    table_wr_t                wr;
    match_t                   match;
    logic [ADDR_W-1:0]        net  [TABLE_ENTRIES];
    logic [ADDR_W-1:0]        mask [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] valid;
    logic [ADDR_W-1:0]        masked_net;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            in_vld_reg <= start && !busy;
            done_reg   <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            in_reg <= request;
        end
        if (in_vld_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign masked_net = in_reg.entry_net & prefix_mask(in_reg.entry_prefix);

    // writes beyond the table leave it unchanged
    always_comb
    begin
        wr.en    = in_vld_reg && (in_reg.command == CMD_WRITE) &&
                   (32'(in_reg.entry_index) < 32'(TABLE_ENTRIES));
        wr.slot  = SLOT_W'(in_reg.entry_index);
        wr.valid = in_reg.entry_valid;
        wr.net   = masked_net;
        wr.mask  = prefix_mask(in_reg.entry_prefix);
    end

    pfc_table u_table
    (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (wr),
        .net   (net),
        .mask  (mask),
        .valid (valid)
    );

    pfc_match u_match
    (
        .query (in_reg.query_addr),
        .net   (net),
        .mask  (mask),
        .valid (valid),
        .match (match)
    );

    always_comb
    begin
        case (in_reg.command)
            CMD_WRITE:
            begin
                result_next.matched     = 1'b0;
                result_next.match_index = in_reg.entry_index;
                result_next.result_addr = masked_net;
            end
            CMD_LOOKUP:
            begin
                result_next.matched     = match.hit;
                result_next.match_index = match.hit ? INDEX_W'(match.slot) : '0;
                result_next.result_addr = match.hit ? match.net : in_reg.query_addr;
            end
            default:
            begin
                result_next = '0;
            end
        endcase
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// File: rtl/pfc_checker.sv
module pfc_checker
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input pfc_pkg::request_t request,
    input logic              done,
    input pfc_pkg::result_t  result
);
    import pfc_pkg::*;

    // every accepted item yields a result
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("item accepted without a result");

    // no result without an item behind it
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result without an accepted item");

    // writes never report a match
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(request.command == CMD_WRITE, 2)) |-> !result.matched)
        else $error("write reported a match");

    // a lookup miss returns the query and slot zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.matched && $past(request.command == CMD_LOOKUP, 2))
        |-> (result.result_addr == $past(request.query_addr, 2) &&
             result.match_index == '0))
        else $error("lookup miss result wrong");

endmodule

bind ipv4_first_match_prefix_classifier_core pfc_checker u_pfc_checker (.*);
